// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pds_pkg.sv
// Types, codes and constants of the presence distance smoother.
package pds_pkg;

    localparam int RING_DEPTH  = 3;
    localparam int DIST_W      = 16;
    localparam int DIV_W       = 19;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = DIV_W + RECIP_W;

    typedef struct packed {
        logic              action;
        logic              target_present;
        logic [DIST_W-1:0] sample_distance_mm;
        logic [DIST_W-1:0] detect_distance_mm;
    } pds_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] display_mm;
        logic [DIST_W-1:0] stable_mm;
        logic [DIST_W-1:0] average_mm;
        logic [2:0]        trend_code;
    } pds_out_t;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [2:0] TREND_NONE     = 3'd0;
    localparam logic [2:0] TREND_UNKNOWN  = 3'd1;
    localparam logic [2:0] TREND_APPROACH = 3'd2;
    localparam logic [2:0] TREND_LEAVE    = 3'd3;
    localparam logic [2:0] TREND_STABLE   = 3'd4;

    localparam logic [1:0] CFG_TREND_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_FAR_JUMP_CONFIRM  = 2'd1;
    localparam logic [1:0] CFG_LOCK_AFTER_STABLE = 2'd2;

    localparam logic [9:0] RST_TREND_THRESHOLD   = 10'd120;
    localparam logic [3:0] RST_FAR_JUMP_CONFIRM  = 4'd4;
    localparam logic [4:0] RST_LOCK_AFTER_STABLE = 5'd6;

    localparam logic [DIST_W-1:0] JUMP_MIN_MM     = 16'd120;
    localparam logic [DIST_W-1:0] JUMP_GAP_MM     = 16'd40;
    localparam logic [DIST_W-1:0] LOCK_HOLD_MM    = 16'd60;
    localparam logic [DIST_W-1:0] LOCK_DRIFT_MM   = 16'd140;
    localparam logic [DIST_W-1:0] BLEND_FINE_MM   = 16'd100;
    localparam logic [DIST_W-1:0] BLEND_COARSE_MM = 16'd180;
    localparam logic [DIST_W-1:0] SLEW_WIDE_MM    = 16'd500;
    localparam logic [DIST_W-1:0] SLEW_UP_WIDE    = 16'd380;
    localparam logic [DIST_W-1:0] SLEW_UP_NARROW  = 16'd240;
    localparam logic [DIST_W-1:0] SLEW_DN_WIDE    = 16'd260;
    localparam logic [DIST_W-1:0] SLEW_DN_NARROW  = 16'd180;
    localparam logic [4:0]        STABLE_MAX      = 5'd20;
    localparam logic [1:0]        DRIFT_CONFIRM   = 2'd3;

    localparam logic [2:0] DIV_BY_FIVE = 3'd5;
    localparam logic [2:0] DIV_BY_SIX  = 3'd6;

    localparam logic [RECIP_W-1:0] RECIP_BY_1 = RECIP_W'(1 << RECIP_SHIFT);
    localparam logic [RECIP_W-1:0] RECIP_BY_2 = RECIP_W'((1 << RECIP_SHIFT) / 2);
    localparam logic [RECIP_W-1:0] RECIP_BY_3 = RECIP_W'((1 << RECIP_SHIFT) / 3);
    localparam logic [RECIP_W-1:0] RECIP_BY_5 = RECIP_W'((1 << RECIP_SHIFT) / 5);
    localparam logic [RECIP_W-1:0] RECIP_BY_6 = RECIP_W'((1 << RECIP_SHIFT) / 6);

    // Truncated reciprocal; the quotient estimate is low by at most one.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            3'd2:    r = RECIP_BY_2;
            3'd3:    r = RECIP_BY_3;
            3'd5:    r = RECIP_BY_5;
            3'd6:    r = RECIP_BY_6;
            default: r = RECIP_BY_1;
        endcase
        return r;
    endfunction

    // Product of a quotient and one of the small divisors, by shift and add.
    function automatic logic [DIV_W-1:0] times_small(input logic [DIV_W-1:0] q,
                                                     input logic [2:0] d);
        logic [DIV_W-1:0] p;
        case (d)
            3'd2:    p = q << 1;
            3'd3:    p = (q << 1) + q;
            3'd5:    p = (q << 2) + q;
            3'd6:    p = (q << 2) + (q << 1);
            default: p = q;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/presence_distance_smoother.sv
// Presence distance smoother: sample ring, trend, far-jump rejection and display smoothing.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+---------------------------------
//   input   | s_valid s_ready s_data                  | frame or tick item
//   result  | m_valid m_ready m_data                  | one result per tick
//   config  | cfg_valid cfg_ready cfg_index cfg_data  | register write, ready out of reset
//
// A frame is taken in the idle state. A tick with no target goes straight to the
// finish state; a tick with a target steps through the sequencer states and the
// shared divide-by-constant unit (multiply, then correction; used once or twice).
// s_ready is low while a tick is in work; a finished result waits in the output
// register and the block idles again once it is loaded. Reset is synchronous and
// clears all filter state and the registers to their defaults.
module presence_distance_smoother (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pds_pkg::pds_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pds_pkg::pds_out_t   m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data
);

    localparam int DW = pds_pkg::DIST_W;
    localparam int XW = pds_pkg::DIV_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SUM    = 4'd1;
    localparam logic [3:0] ST_DMUL   = 4'd2;
    localparam logic [3:0] ST_DCOR   = 4'd3;
    localparam logic [3:0] ST_TREND  = 4'd4;
    localparam logic [3:0] ST_REJECT = 4'd5;
    localparam logic [3:0] ST_SM1    = 4'd6;
    localparam logic [3:0] ST_SM2    = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    localparam logic [1:0] DST_MEAN  = 2'd0;
    localparam logic [1:0] DST_LOCK  = 2'd1;
    localparam logic [1:0] DST_SHOWN = 2'd2;

    // control and filter state
    logic [3:0]    state_reg, state_next;
    logic [DW-1:0] ring_reg [pds_pkg::RING_DEPTH];
    logic [DW-1:0] ring_next [pds_pkg::RING_DEPTH];
    logic [1:0]    wr_idx_reg, wr_idx_next;
    logic [1:0]    fill_reg, fill_next;
    logic [DW-1:0] prev_mean_reg, prev_mean_next;
    logic [DW-1:0] shown_reg, shown_next;
    logic [DW-1:0] pend_mm_reg, pend_mm_next;
    logic [3:0]    pend_ticks_reg, pend_ticks_next;
    logic [4:0]    stab_ticks_reg, stab_ticks_next;
    logic [DW-1:0] lock_reg, lock_next;
    logic [1:0]    drift_reg, drift_next;
    logic [9:0]    thresh_reg, thresh_next;
    logic [3:0]    confirm_reg, confirm_next;
    logic [4:0]    lock_after_reg, lock_after_next;
    logic          m_valid_reg, m_valid_next;

    // payload and working registers
    pds_pkg::pds_in_t  in_reg, in_next;
    pds_pkg::pds_out_t m_data_reg, m_data_next;
    logic [XW-1:0]     div_x_reg, div_x_next;
    logic [2:0]        div_d_reg, div_d_next;
    logic [1:0]        div_dst_reg, div_dst_next;
    logic [pds_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [DW-1:0]     med_reg, med_next;
    logic [DW-1:0]     mean_reg, mean_next;
    logic [DW-1:0]     stable_reg, stable_next;
    logic [2:0]        trend_reg, trend_next;

    // ring sum and median
    logic [XW-1:0] ring_sum;
    logic [DW:0]   pair_sum;
    logic [DW-1:0] med_lo, med_hi, med_mid, med_calc;
    logic [1:0]    wr_idx_eff;

    assign ring_sum = ((fill_reg != 2'd0) ? XW'(ring_reg[0]) : '0)
                    + ((fill_reg >= 2'd2) ? XW'(ring_reg[1]) : '0)
                    + ((fill_reg == 2'd3) ? XW'(ring_reg[2]) : '0);
    assign pair_sum = {1'b0, ring_reg[0]} + {1'b0, ring_reg[1]};
    assign med_lo   = (ring_reg[1] < ring_reg[0]) ? ring_reg[1] : ring_reg[0];
    assign med_hi   = (ring_reg[1] < ring_reg[0]) ? ring_reg[0] : ring_reg[1];
    assign med_mid  = (ring_reg[2] < med_hi) ? ring_reg[2] : med_hi;
    assign wr_idx_eff = (wr_idx_reg == 2'd3) ? 2'd0 : wr_idx_reg;

    always_comb begin
        case (fill_reg)
            2'd0:    med_calc = '0;
            2'd1:    med_calc = ring_reg[0];
            2'd2:    med_calc = pair_sum[DW:1];
            default: med_calc = (med_mid < med_lo) ? med_lo : med_mid;
        endcase
    end

    // shared divide-by-constant unit: estimate, then one correction
    logic [XW-1:0] quot_est, quot_prod, quot_rem, quot;

    assign quot_est  = prod_reg[pds_pkg::RECIP_SHIFT +: XW];
    assign quot_prod = pds_pkg::times_small(quot_est, div_d_reg);
    assign quot_rem  = div_x_reg - quot_prod;
    assign quot      = (quot_rem >= XW'(div_d_reg)) ? quot_est + XW'(1) : quot_est;

    // trend of the mean
    logic signed [DW+1:0] mean_diff, thresh_s;
    logic [2:0]           trend_calc;

    assign mean_diff = $signed({2'b00, mean_reg}) - $signed({2'b00, prev_mean_reg});
    assign thresh_s  = $signed({8'b0, thresh_reg});

    always_comb begin
        if (prev_mean_reg == '0 || mean_reg == '0) begin
            trend_calc = pds_pkg::TREND_UNKNOWN;
        end else if (mean_diff <= -thresh_s) begin
            trend_calc = pds_pkg::TREND_APPROACH;
        end else if (mean_diff >= thresh_s) begin
            trend_calc = pds_pkg::TREND_LEAVE;
        end else begin
            trend_calc = pds_pkg::TREND_STABLE;
        end
    end

    // far-jump rejection terms
    logic                 trusted;
    logic signed [DW+1:0] jump_d;
    logic [DW-1:0]        jump_gap;
    logic [3:0]           pend_ticks_inc;

    assign trusted  = (in_reg.detect_distance_mm != '0)
                   && (med_reg == in_reg.detect_distance_mm);
    assign jump_d   = $signed({2'b00, med_reg}) - $signed({2'b00, shown_reg});
    assign jump_gap = (pend_mm_reg > med_reg) ? pend_mm_reg - med_reg : med_reg - pend_mm_reg;
    assign pend_ticks_inc = pend_ticks_reg + 4'd1;

    // display smoothing terms
    logic signed [DW+1:0] sm_d, lk_d, slew_lim, slew_step;
    logic [DW:0]          sm_ad, lk_ad;
    logic [DW-1:0]        lock_eff, slew_shown;
    logic [1:0]           drift_inc;
    logic [XW-1:0]        lock_x6, lock_x5, blend_x6, blend_x5;

    assign sm_d     = $signed({2'b00, stable_reg}) - $signed({2'b00, shown_reg});
    assign sm_ad    = (sm_d < 0) ? (DW+1)'(-sm_d) : (DW+1)'(sm_d);
    assign lock_eff = (lock_reg == '0) ? shown_reg : lock_reg;
    assign lk_d     = $signed({2'b00, stable_reg}) - $signed({2'b00, lock_eff});
    assign lk_ad    = (lk_d < 0) ? (DW+1)'(-lk_d) : (DW+1)'(lk_d);
    assign drift_inc = drift_reg + 2'd1;

    assign lock_x6  = XW'({lock_eff, 2'b00}) + XW'(lock_eff) + XW'(stable_reg);
    assign lock_x5  = XW'({lock_eff, 1'b0}) + XW'(lock_eff) + XW'({stable_reg, 1'b0});
    assign blend_x6 = XW'({shown_reg, 2'b00}) + XW'(shown_reg) + XW'(stable_reg);
    assign blend_x5 = XW'({shown_reg, 2'b00}) + XW'(stable_reg);

    always_comb begin
        if (sm_d > 0) begin
            slew_lim = (sm_ad > (DW+1)'(pds_pkg::SLEW_WIDE_MM))
                     ? $signed({2'b00, pds_pkg::SLEW_UP_WIDE})
                     : $signed({2'b00, pds_pkg::SLEW_UP_NARROW});
        end else begin
            slew_lim = (sm_ad > (DW+1)'(pds_pkg::SLEW_WIDE_MM))
                     ? $signed({2'b00, pds_pkg::SLEW_DN_WIDE})
                     : $signed({2'b00, pds_pkg::SLEW_DN_NARROW});
        end
        if (sm_d > slew_lim) begin
            slew_step = slew_lim;
        end else if (sm_d < -slew_lim) begin
            slew_step = -slew_lim;
        end else begin
            slew_step = sm_d;
        end
    end

    assign slew_shown = DW'($signed({2'b00, shown_reg}) + slew_step);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        ring_next       = ring_reg;
        wr_idx_next     = wr_idx_reg;
        fill_next       = fill_reg;
        prev_mean_next  = prev_mean_reg;
        shown_next      = shown_reg;
        pend_mm_next    = pend_mm_reg;
        pend_ticks_next = pend_ticks_reg;
        stab_ticks_next = stab_ticks_reg;
        lock_next       = lock_reg;
        drift_next      = drift_reg;
        thresh_next     = thresh_reg;
        confirm_next    = confirm_reg;
        lock_after_next = lock_after_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        in_next         = in_reg;
        m_data_next     = m_data_reg;
        div_x_next      = div_x_reg;
        div_d_next      = div_d_reg;
        div_dst_next    = div_dst_reg;
        prod_next       = prod_reg;
        med_next        = med_reg;
        mean_next       = mean_reg;
        stable_next     = stable_reg;
        trend_next      = trend_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pds_pkg::CFG_TREND_THRESHOLD:   thresh_next     = cfg_data;
                pds_pkg::CFG_FAR_JUMP_CONFIRM:  confirm_next    = cfg_data[3:0];
                pds_pkg::CFG_LOCK_AFTER_STABLE: lock_after_next = cfg_data[4:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    if (s_data.action == pds_pkg::ACT_FRAME) begin
                        if (s_data.target_present && s_data.sample_distance_mm != '0) begin
                            ring_next[wr_idx_eff] = s_data.sample_distance_mm;
                            wr_idx_next = (wr_idx_eff == 2'd2) ? 2'd0 : wr_idx_eff + 2'd1;
                            if (fill_reg != 2'd3) begin
                                fill_next = fill_reg + 2'd1;
                            end
                        end else begin
                            // drop all filter state
                            for (int i = 0; i < pds_pkg::RING_DEPTH; i++) begin
                                ring_next[i] = '0;
                            end
                            wr_idx_next     = '0;
                            fill_next       = '0;
                            prev_mean_next  = '0;
                            shown_next      = '0;
                            pend_mm_next    = '0;
                            pend_ticks_next = '0;
                            stab_ticks_next = '0;
                            lock_next       = '0;
                            drift_next      = '0;
                        end
                    end else if (!s_data.target_present) begin
                        shown_next      = '0;
                        stab_ticks_next = '0;
                        lock_next       = '0;
                        drift_next      = '0;
                        stable_next     = '0;
                        mean_next       = '0;
                        trend_next      = pds_pkg::TREND_NONE;
                        state_next      = ST_FINISH;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                div_x_next   = ring_sum;
                div_d_next   = (fill_reg == 2'd0) ? 3'd1 : {1'b0, fill_reg};
                div_dst_next = DST_MEAN;
                med_next     = med_calc;
                state_next   = ST_DMUL;
            end
            ST_DMUL: begin
                prod_next  = div_x_reg * pds_pkg::recip_of(div_d_reg);
                state_next = ST_DCOR;
            end
            ST_DCOR: begin
                case (div_dst_reg)
                    DST_MEAN: begin
                        mean_next  = quot[DW-1:0];
                        state_next = ST_TREND;
                    end
                    DST_LOCK: begin
                        lock_next  = quot[DW-1:0];
                        shown_next = quot[DW-1:0];
                        state_next = ST_FINISH;
                    end
                    default: begin
                        shown_next = quot[DW-1:0];
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_TREND: begin
                trend_next     = trend_calc;
                prev_mean_next = mean_reg;
                state_next     = ST_REJECT;
            end
            ST_REJECT: begin
                state_next = ST_SM1;
                if (med_reg == '0 || shown_reg == '0 || trusted
                        || jump_d <= $signed({2'b00, pds_pkg::JUMP_MIN_MM})
                        || trend_reg != pds_pkg::TREND_STABLE) begin
                    pend_mm_next    = '0;
                    pend_ticks_next = '0;
                    stable_next     = med_reg;
                end else if (pend_mm_reg == '0 || jump_gap > pds_pkg::JUMP_GAP_MM) begin
                    // start confirming a new far jump
                    pend_mm_next    = med_reg;
                    pend_ticks_next = 4'd1;
                    stable_next     = shown_reg;
                end else if (pend_ticks_inc < confirm_reg) begin
                    pend_ticks_next = pend_ticks_inc;
                    stable_next     = shown_reg;
                end else begin
                    pend_mm_next    = '0;
                    pend_ticks_next = '0;
                    stable_next     = med_reg;
                end
            end
            ST_SM1: begin
                if (stable_reg == '0) begin
                    shown_next      = '0;
                    stab_ticks_next = '0;
                    lock_next       = '0;
                    drift_next      = '0;
                    state_next      = ST_FINISH;
                end else if (shown_reg == '0) begin
                    shown_next      = stable_reg;
                    stab_ticks_next = '0;
                    lock_next       = stable_reg;
                    drift_next      = '0;
                    state_next      = ST_FINISH;
                end else begin
                    if (trend_reg == pds_pkg::TREND_STABLE) begin
                        if (stab_ticks_reg < pds_pkg::STABLE_MAX) begin
                            stab_ticks_next = stab_ticks_reg + 5'd1;
                        end
                    end else begin
                        stab_ticks_next = '0;
                        lock_next       = shown_reg;
                        drift_next      = '0;
                    end
                    state_next = ST_SM2;
                end
            end
            ST_SM2: begin
                if (stab_ticks_reg >= lock_after_reg) begin
                    lock_next = lock_eff;
                    if (lk_ad <= (DW+1)'(pds_pkg::LOCK_HOLD_MM)) begin
                        drift_next = '0;
                        shown_next = lock_eff;
                        state_next = ST_FINISH;
                    end else if (lk_ad <= (DW+1)'(pds_pkg::LOCK_DRIFT_MM)) begin
                        if (drift_inc == pds_pkg::DRIFT_CONFIRM) begin
                            drift_next   = '0;
                            div_x_next   = lock_x6;
                            div_d_next   = pds_pkg::DIV_BY_SIX;
                            div_dst_next = DST_LOCK;
                            state_next   = ST_DMUL;
                        end else begin
                            drift_next = drift_inc;
                            shown_next = lock_eff;
                            state_next = ST_FINISH;
                        end
                    end else begin
                        drift_next   = '0;
                        div_x_next   = lock_x5;
                        div_d_next   = pds_pkg::DIV_BY_FIVE;
                        div_dst_next = DST_LOCK;
                        state_next   = ST_DMUL;
                    end
                end else begin
                    lock_next  = shown_reg;
                    drift_next = '0;
                    if (sm_ad <= (DW+1)'(pds_pkg::BLEND_FINE_MM)) begin
                        div_x_next   = blend_x6;
                        div_d_next   = pds_pkg::DIV_BY_SIX;
                        div_dst_next = DST_SHOWN;
                        state_next   = ST_DMUL;
                    end else if (sm_ad <= (DW+1)'(pds_pkg::BLEND_COARSE_MM)) begin
                        div_x_next   = blend_x5;
                        div_d_next   = pds_pkg::DIV_BY_FIVE;
                        div_dst_next = DST_SHOWN;
                        state_next   = ST_DMUL;
                    end else begin
                        shown_next = slew_shown;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.display_mm  = shown_reg;
                    m_data_next.stable_mm   = stable_reg;
                    m_data_next.average_mm  = mean_reg;
                    m_data_next.trend_code  = trend_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < pds_pkg::RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            wr_idx_reg     <= '0;
            fill_reg       <= '0;
            prev_mean_reg  <= '0;
            shown_reg      <= '0;
            pend_mm_reg    <= '0;
            pend_ticks_reg <= '0;
            stab_ticks_reg <= '0;
            lock_reg       <= '0;
            drift_reg      <= '0;
            thresh_reg     <= pds_pkg::RST_TREND_THRESHOLD;
            confirm_reg    <= pds_pkg::RST_FAR_JUMP_CONFIRM;
            lock_after_reg <= pds_pkg::RST_LOCK_AFTER_STABLE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ring_reg       <= ring_next;
            wr_idx_reg     <= wr_idx_next;
            fill_reg       <= fill_next;
            prev_mean_reg  <= prev_mean_next;
            shown_reg      <= shown_next;
            pend_mm_reg    <= pend_mm_next;
            pend_ticks_reg <= pend_ticks_next;
            stab_ticks_reg <= stab_ticks_next;
            lock_reg       <= lock_next;
            drift_reg      <= drift_next;
            thresh_reg     <= thresh_next;
            confirm_reg    <= confirm_next;
            lock_after_reg <= lock_after_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        m_data_reg  <= m_data_next;
        div_x_reg   <= div_x_next;
        div_d_reg   <= div_d_next;
        div_dst_reg <= div_dst_next;
        prod_reg    <= prod_next;
        med_reg     <= med_next;
        mean_reg    <= mean_next;
        stable_reg  <= stable_next;
        trend_reg   <= trend_next;
    end

    assign s_ready   = (state_reg == ST_IDLE) && aresetn;
    assign cfg_ready = aresetn;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

// File: rtl/pds_checker.sv
// Port-level checks of the presence distance smoother, bound to the top level.
`include "assert_macros.svh"

module pds_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input pds_pkg::pds_in_t    s_data,
    input logic                m_valid,
    input logic                m_ready,
    input pds_pkg::pds_out_t   m_data
);

    logic frame_acc, tick_acc;

    assign frame_acc = s_valid && s_ready && (s_data.action == pds_pkg::ACT_FRAME);
    assign tick_acc  = s_valid && s_ready && (s_data.action == pds_pkg::ACT_TICK);

    `PDS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `PDS_ASSERT_NEXT(a_frame_no_result, frame_acc && !m_valid, !m_valid, "frame produced a result")
    `PDS_ASSERT_NEXT(a_frame_one_cycle, frame_acc, s_ready, "frame held the input side")
    `PDS_ASSERT_NEXT(a_tick_busy, tick_acc, !s_ready, "tick accepted without going busy")
    `PDS_ASSERT_NOW(a_absent_zero, m_valid && m_data.trend_code == pds_pkg::TREND_NONE, m_data.display_mm == '0 && m_data.stable_mm == '0 && m_data.average_mm == '0, "absent result not zero")

endmodule

bind presence_distance_smoother pds_checker u_pds_checker (.*);

// File: tb/presence_distance_smoother_tb.sv
// Self-checking testbench for the presence distance smoother.
`timescale 1ns / 100ps

module presence_distance_smoother_tb;

    localparam int         DW               = pds_pkg::DIST_W;
    localparam int         SETTLE_CYCLES    = 16;
    localparam int         REPORT_LIMIT     = 60;
    localparam int         RUN_LIMIT_NS     = 4_000_000;
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int JUMP_MIN     = int'(pds_pkg::JUMP_MIN_MM);
    localparam int LOCK_HOLD    = int'(pds_pkg::LOCK_HOLD_MM);
    localparam int LOCK_DRIFT   = int'(pds_pkg::LOCK_DRIFT_MM);
    localparam int BLEND_FINE   = int'(pds_pkg::BLEND_FINE_MM);
    localparam int BLEND_COARSE = int'(pds_pkg::BLEND_COARSE_MM);
    localparam int SLEW_WIDE    = int'(pds_pkg::SLEW_WIDE_MM);
    localparam int UP_WIDE      = int'(pds_pkg::SLEW_UP_WIDE);
    localparam int UP_NARROW    = int'(pds_pkg::SLEW_UP_NARROW);
    localparam int DN_WIDE      = int'(pds_pkg::SLEW_DN_WIDE);
    localparam int DN_NARROW    = int'(pds_pkg::SLEW_DN_NARROW);

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    pds_pkg::pds_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    pds_pkg::pds_out_t m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [9:0]        cfg_data;

    presence_distance_smoother dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted block state and registers
    logic [DW-1:0] ring_mm [pds_pkg::RING_DEPTH];
    logic [1:0]    ring_wr;
    logic [1:0]    ring_fill;
    logic [DW-1:0] last_mean_mm;
    logic [DW-1:0] shown_mm;
    logic [DW-1:0] jump_mm;
    logic [3:0]    jump_ticks;
    logic [4:0]    steady_ticks;
    logic [DW-1:0] lock_mm;
    logic [1:0]    drift_cnt;
    logic [9:0]    trend_thresh;
    logic [3:0]    jump_confirm;
    logic [4:0]    lock_after;

    pds_pkg::pds_out_t pending_readings [$];

    int fail_count      = 0;
    int items_sent      = 0;
    int readings_seen   = 0;
    int reg_writes      = 0;
    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_request    = 0;
    int hold_left       = 0;
    int walk_mm         = 1000;
    int run_left        = 0;
    logic [DW-1:0] last_sample = 16'd1000;

    function automatic void clear_filter_state();
        for (int i = 0; i < pds_pkg::RING_DEPTH; i++) ring_mm[i] = '0;
        ring_wr      = '0;
        ring_fill    = '0;
        last_mean_mm = '0;
        shown_mm     = '0;
        jump_mm      = '0;
        jump_ticks   = '0;
        steady_ticks = '0;
        lock_mm      = '0;
        drift_cnt    = '0;
    endfunction

    function automatic void drop_display();
        shown_mm     = '0;
        steady_ticks = '0;
        lock_mm      = '0;
        drift_cnt    = '0;
    endfunction

    function automatic logic [DW-1:0] ring_mean_mm();
        int unsigned total;
        total = 0;
        if (ring_fill == 0) return '0;
        for (int i = 0; i < int'(ring_fill); i++) total += 32'(ring_mm[i]);
        return DW'(total / 32'(ring_fill));
    endfunction

    function automatic logic [DW-1:0] ring_median_mm();
        int unsigned a, b, c, t;
        a = 32'(ring_mm[0]);
        b = 32'(ring_mm[1]);
        c = 32'(ring_mm[2]);
        if (ring_fill == 0) return '0;
        if (ring_fill == 1) return DW'(a);
        if (ring_fill == 2) return DW'((a + b) / 2);
        if (b < a) begin
            t = a;
            a = b;
            b = t;
        end
        if (c < b) b = c;
        if (b < a) b = a;
        return DW'(b);
    endfunction

    function automatic logic [2:0] trend_from(input logic [DW-1:0] mean_mm);
        int m, p, th, diff;
        m = int'(mean_mm);
        p = int'(last_mean_mm);
        th = int'(trend_thresh);
        if (p == 0 || m == 0) return pds_pkg::TREND_UNKNOWN;
        diff = m - p;
        if (diff <= -th) return pds_pkg::TREND_APPROACH;
        if (diff >= th) return pds_pkg::TREND_LEAVE;
        return pds_pkg::TREND_STABLE;
    endfunction

    // Hold the shown distance while an outward jump waits for confirmation.
    function automatic logic [DW-1:0] reject_jump(input logic [DW-1:0] cand,
                                                  input logic [2:0] trend,
                                                  input bit trusted);
        int c, s;
        logic [DW-1:0] gap;
        c = int'(cand);
        s = int'(shown_mm);
        if (c == 0 || s == 0 || trusted || c - s <= JUMP_MIN
                || trend != pds_pkg::TREND_STABLE) begin
            jump_mm    = '0;
            jump_ticks = '0;
            return cand;
        end
        gap = (jump_mm > cand) ? jump_mm - cand : cand - jump_mm;
        if (jump_mm == 0 || gap > pds_pkg::JUMP_GAP_MM) begin
            jump_mm    = cand;
            jump_ticks = 4'd1;
            return shown_mm;
        end
        jump_ticks = jump_ticks + 4'd1;
        if (jump_ticks < jump_confirm) return shown_mm;
        jump_mm    = '0;
        jump_ticks = '0;
        return cand;
    endfunction

    function automatic logic [DW-1:0] smooth_mm(input logic [DW-1:0] raw,
                                                input logic [2:0] trend);
        int r, s, l, diff, mag, lmag, lim;
        if (raw == 0) begin
            drop_display();
            return '0;
        end
        if (shown_mm == 0) begin
            shown_mm     = raw;
            steady_ticks = '0;
            lock_mm      = raw;
            drift_cnt    = '0;
            return raw;
        end
        if (trend == pds_pkg::TREND_STABLE) begin
            if (steady_ticks < pds_pkg::STABLE_MAX) steady_ticks++;
        end else begin
            steady_ticks = '0;
            lock_mm      = shown_mm;
            drift_cnt    = '0;
        end
        r = int'(raw);
        s = int'(shown_mm);
        diff = r - s;
        mag = (diff < 0) ? -diff : diff;
        if (steady_ticks >= lock_after) begin
            if (lock_mm == 0) lock_mm = shown_mm;
            l = int'(lock_mm);
            lmag = (r < l) ? l - r : r - l;
            if (lmag <= LOCK_HOLD) begin
                drift_cnt = '0;
            end else if (lmag <= LOCK_DRIFT) begin
                drift_cnt++;
                if (drift_cnt >= pds_pkg::DRIFT_CONFIRM) begin
                    drift_cnt = '0;
                    lock_mm   = DW'((l * 5 + r) / 6);
                end
            end else begin
                drift_cnt = '0;
                lock_mm   = DW'((l * 3 + r * 2) / 5);
            end
            shown_mm = lock_mm;
            return shown_mm;
        end
        lock_mm   = shown_mm;
        drift_cnt = '0;
        if (mag <= BLEND_FINE) begin
            shown_mm = DW'((s * 5 + r) / 6);
        end else if (mag <= BLEND_COARSE) begin
            shown_mm = DW'((s * 4 + r) / 5);
        end else begin
            // limit the step, wider for large moves
            if (diff > 0) lim = (mag > SLEW_WIDE) ? UP_WIDE : UP_NARROW;
            else          lim = (mag > SLEW_WIDE) ? DN_WIDE : DN_NARROW;
            if (diff > lim)  diff = lim;
            if (diff < -lim) diff = -lim;
            shown_mm = DW'(s + diff);
        end
        return shown_mm;
    endfunction

    task automatic step_smoother(input pds_pkg::pds_in_t item, output bit has_reading,
                                 output pds_pkg::pds_out_t reading);
        logic [DW-1:0] mean_mm, median_mm, held_mm, shown;
        logic [2:0]    trend;
        bit            trusted;
        has_reading = 1'b0;
        reading     = '0;
        if (item.action == pds_pkg::ACT_FRAME) begin
            if (item.target_present && item.sample_distance_mm != 0) begin
                if (ring_wr >= pds_pkg::RING_DEPTH) ring_wr = '0;
                ring_mm[ring_wr] = item.sample_distance_mm;
                ring_wr = (ring_wr == pds_pkg::RING_DEPTH - 1) ? 2'd0 : ring_wr + 2'd1;
                if (ring_fill < pds_pkg::RING_DEPTH) ring_fill++;
            end else begin
                clear_filter_state();
            end
            return;
        end
        has_reading = 1'b1;
        if (!item.target_present) begin
            drop_display();
            return;
        end
        mean_mm   = ring_mean_mm();
        trend     = trend_from(mean_mm);
        median_mm = ring_median_mm();
        trusted   = (item.detect_distance_mm != 0) && (median_mm == item.detect_distance_mm);
        held_mm   = reject_jump(median_mm, trend, trusted);
        shown     = smooth_mm(held_mm, trend);
        last_mean_mm = mean_mm;
        reading.display_mm = shown;
        reading.stable_mm  = held_mm;
        reading.average_mm = mean_mm;
        reading.trend_code = trend;
    endtask

    function automatic pds_pkg::pds_in_t frame_item(input bit present,
                                                    input logic [DW-1:0] frame_mm);
        pds_pkg::pds_in_t item;
        item.action             = pds_pkg::ACT_FRAME;
        item.target_present     = present;
        item.sample_distance_mm = frame_mm;
        item.detect_distance_mm = DW'($urandom);
        return item;
    endfunction

    function automatic pds_pkg::pds_in_t tick_item(input bit present, input logic [DW-1:0] det);
        pds_pkg::pds_in_t item;
        item.action             = pds_pkg::ACT_TICK;
        item.target_present     = present;
        item.sample_distance_mm = DW'($urandom);
        item.detect_distance_mm = det;
        return item;
    endfunction

    function automatic logic [DW-1:0] clamp_mm(input int v);
        if (v < 1) return 16'd1;
        if (v > 65535) return 16'hFFFF;
        return DW'(v);
    endfunction

    // Runs of plausible frames and ticks, each run opened by one noise transaction.
    task automatic next_random_item(output pds_pkg::pds_in_t item);
        logic [63:0]   bits;
        logic [DW-1:0] det;
        int            step;
        int            pick;
        if (run_left == 0) begin
            run_left = $urandom_range(60, 12);
            if ($urandom_range(3) == 0) walk_mm = $urandom_range(65535, 60000);
            else                        walk_mm = $urandom_range(6000, 150);
            bits = {$urandom, $urandom};
            item = pds_pkg::pds_in_t'(bits[$bits(pds_pkg::pds_in_t)-1:0]);
            case ($urandom_range(3))
                0: item.target_present = 1'b0;
                1: begin
                    item.action             = pds_pkg::ACT_FRAME;
                    item.sample_distance_mm = '0;
                end
                default: ;
            endcase
            return;
        end
        run_left--;
        if ($urandom_range(99) < 40) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                step = $urandom_range(80);
                step = step - 40;
            end else if (pick < 96) begin
                step = $urandom_range(700, 100);
                if ($urandom_range(1) != 0) step = -step;
            end else begin
                step = $urandom_range(65535);
                step = step - walk_mm;
            end
            walk_mm = int'(clamp_mm(walk_mm + step));
            step = $urandom_range(40);
            last_sample = clamp_mm(walk_mm + step - 20);
            item = frame_item(1'b1, last_sample);
        end else begin
            case ($urandom_range(4))
                0, 1:    det = last_sample;
                2:       det = '0;
                3:       det = DW'(walk_mm);
                default: det = DW'($urandom);
            endcase
            item = tick_item(1'b1, det);
        end
    endtask

    task automatic offer_item(input pds_pkg::pds_in_t item);
        bit                has_reading;
        pds_pkg::pds_out_t reading;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        step_smoother(item, has_reading, reading);
        if (has_reading) pending_readings.push_back(reading);
        items_sent++;
    endtask

    // Drop valid, drain all readings, then let the block settle.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] reg_index, input logic [9:0] value);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (reg_index)
            pds_pkg::CFG_TREND_THRESHOLD:   trend_thresh = value;
            pds_pkg::CFG_FAR_JUMP_CONFIRM:  jump_confirm = value[3:0];
            pds_pkg::CFG_LOCK_AFTER_STABLE: lock_after   = value[4:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic test_empty_and_absent();
        set_idling(0, 0);
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(tick_item(1'b0, 16'hFFFF));
        offer_item(frame_item(1'b1, 16'hFFFF));
        offer_item(tick_item(1'b1, 16'hFFFF));
        offer_item(frame_item(1'b1, 16'd0));
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(frame_item(1'b1, 16'd1));
        offer_item(frame_item(1'b1, 16'd2));
        offer_item(frame_item(1'b1, 16'hFFFF));
        // fourth sample wraps the ring write index
        offer_item(frame_item(1'b1, 16'd3));
        offer_item(tick_item(1'b1, 16'd3));
        offer_item(frame_item(1'b0, 16'd500));
        offer_item(tick_item(1'b1, 16'd0));
    endtask

    task automatic test_far_jump_confirm();
        write_reg(pds_pkg::CFG_TREND_THRESHOLD, 10'd1023);
        write_reg(pds_pkg::CFG_FAR_JUMP_CONFIRM, 10'd0);
        offer_item(frame_item(1'b1, 16'd1000));
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(frame_item(1'b1, 16'd1600));
        offer_item(frame_item(1'b1, 16'd1600));
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(tick_item(1'b1, 16'd0));
    endtask

    task automatic test_zero_threshold();
        write_reg(pds_pkg::CFG_TREND_THRESHOLD, 10'd0);
        offer_item(frame_item(1'b1, 16'd800));
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(frame_item(1'b1, 16'd900));
        offer_item(tick_item(1'b1, 16'd0));
    endtask

    task automatic test_lock_zero_and_bad_index();
        write_reg(pds_pkg::CFG_LOCK_AFTER_STABLE, 10'd0);
        write_reg(CFG_UNUSED_INDEX, 10'h3FF);
        offer_item(tick_item(1'b1, 16'd0));
        offer_item(tick_item(1'b1, 16'd0));
    endtask

    task automatic test_random_settings();
        logic [9:0]       th;
        logic [3:0]       cf;
        logic [4:0]       lk;
        pds_pkg::pds_in_t item;
        for (int phase = 0; phase < 8; phase++) begin
            th = 10'($urandom);
            cf = 4'($urandom);
            lk = 5'($urandom);
            case (phase)
                0: begin
                    th = pds_pkg::RST_TREND_THRESHOLD;
                    cf = pds_pkg::RST_FAR_JUMP_CONFIRM;
                    lk = pds_pkg::RST_LOCK_AFTER_STABLE;
                end
                1: begin
                    th = 10'd1023;
                    cf = 4'd15;
                    lk = 5'd20;
                end
                2: begin
                    th = 10'd0;
                    cf = 4'd1;
                    lk = 5'd1;
                end
                3: begin
                    cf = 4'd0;
                    lk = 5'd31;
                end
                4: begin
                    th = 10'd1;
                    cf = 4'($urandom_range(15, 1));
                    lk = 5'd0;
                end
                5: th = 10'($urandom_range(300, 40));
                default: ;
            endcase
            write_reg(pds_pkg::CFG_TREND_THRESHOLD, th);
            // spare upper data bits must not reach the narrow registers
            write_reg(pds_pkg::CFG_FAR_JUMP_CONFIRM, {6'($urandom), cf});
            write_reg(pds_pkg::CFG_LOCK_AFTER_STABLE, {5'($urandom), lk});
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(57, 0);
                2: set_idling(0, 57);
                default: set_idling(16, 16);
            endcase
            repeat (65) begin
                next_random_item(item);
                offer_item(item);
            end
        end
    endtask

    task automatic test_backpressure();
        pds_pkg::pds_in_t item;
        quiesce();
        set_idling(0, 0);
        hold_request = 300;
        repeat (24) begin
            next_random_item(item);
            offer_item(item);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d readings outstanding", pending_readings.size());
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_reading
        pds_pkg::pds_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $error("unexpected reading: display_mm %0d", m_data.display_mm);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                readings_seen++;
                if (m_data.display_mm !== want.display_mm) begin
                    if (fail_count < REPORT_LIMIT)
                        $error("display_mm: expected %0d, got %0d",
                               want.display_mm, m_data.display_mm);
                    fail_count++;
                end
                if (m_data.stable_mm !== want.stable_mm) begin
                    if (fail_count < REPORT_LIMIT)
                        $error("stable_mm: expected %0d, got %0d",
                               want.stable_mm, m_data.stable_mm);
                    fail_count++;
                end
                if (m_data.average_mm !== want.average_mm) begin
                    if (fail_count < REPORT_LIMIT)
                        $error("average_mm: expected %0d, got %0d",
                               want.average_mm, m_data.average_mm);
                    fail_count++;
                end
                if (m_data.trend_code !== want.trend_code) begin
                    if (fail_count < REPORT_LIMIT)
                        $error("trend_code: expected %0d, got %0d",
                               want.trend_code, m_data.trend_code);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        trend_thresh = pds_pkg::RST_TREND_THRESHOLD;
        jump_confirm = pds_pkg::RST_FAR_JUMP_CONFIRM;
        lock_after   = pds_pkg::RST_LOCK_AFTER_STABLE;
        clear_filter_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_absent();
        test_far_jump_confirm();
        test_zero_threshold();
        test_lock_zero_and_bad_index();
        test_random_settings();
        test_backpressure();
        quiesce();

        $display("Covered %0d transactions in, %0d readings checked, %0d register writes.",
                 items_sent, readings_seen, reg_writes);
        $display("Idling mixes: none, sender gaps, receiver stalls, both; one long hold-off.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: presence_distance_smoother.f
+incdir+rtl
rtl/pds_pkg.sv
rtl/presence_distance_smoother.sv
rtl/pds_checker.sv
tb/presence_distance_smoother_tb.sv
